// ----- rtl/assert_macros.svh -----
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, off while reset is low.
`define CRR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property that must hold in the cycle after its trigger.
`define CRR_ASSERT_NEXT(lbl, ante, cons, msg) \
  `CRR_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ----- rtl/crr_pkg.sv -----
`timescale 1ns / 1ps
package crr_pkg;

  localparam int STAGE_COUNT       = 7;
  localparam int WINDOWS_PER_STAGE = 64;
  localparam int WORD_W            = 32;
  localparam int KIND_W            = 2;
  localparam int STAGE_W           = 3;
  localparam int QUEUE_DEPTH       = 2;

  localparam int STAGE_IDX_W = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;
  localparam int SCAN_W      = $clog2(STAGE_COUNT + 1);
  localparam int FILL_W      = $clog2(WINDOWS_PER_STAGE + 1);
  localparam int WIN_IDX_W   = (WINDOWS_PER_STAGE > 1) ? $clog2(WINDOWS_PER_STAGE) : 1;
  localparam int TABLE_DEPTH = STAGE_COUNT * WINDOWS_PER_STAGE;
  localparam int TABLE_AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int ENTRY_W     = 3 * WORD_W;

  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  localparam logic [WORD_W-1:0] NO_VALUE = '1;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_QUERY,
    OP_CLEAR,
    OP_DROP,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e                    op;
    logic [STAGE_IDX_W-1:0] stage;
    logic [WORD_W-1:0]      dst;
    logic [WORD_W-1:0]      src;
    logic [WORD_W-1:0]      len;
    logic [WORD_W-1:0]      key;
  } cmd_t;

endpackage

// ----- rtl/cascaded_range_remap.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// input     in         push / full          kind, stage, dest_start, source_start,
//                                           span_length, seed_key
// result    out        empty / pop          mapped_value, lowest_so_far, status
//
// Load, clear, dropped and unused items are handled straight from idle in the back end.
// A query scans each stage's filled windows through the table RAM until a hit in that
// stage, then goes on to the next stage; the result is posted after the last stage.
// Reset clears stage fill counts and sets the minimum to all ones; no clearing pass.
// A two-entry queue keeps taking items while the back end scans or a result waits.
module cascaded_range_remap import crr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [KIND_W-1:0]  kind_i,
  input  logic [STAGE_W-1:0] stage_i,
  input  logic [WORD_W-1:0]  dest_start_i,
  input  logic [WORD_W-1:0]  source_start_i,
  input  logic [WORD_W-1:0]  span_length_i,
  input  logic [WORD_W-1:0]  seed_key_i,
  output logic               empty,
  input  logic               pop,
  output logic [WORD_W-1:0]  mapped_value_o,
  output logic [WORD_W-1:0]  lowest_so_far_o,
  output logic               status_o
);

  cmd_t front_cmd, queue_cmd;
  logic queue_valid, queue_take, res_valid;

  crr_front u_front (
    .kind_i         (kind_i),
    .stage_i        (stage_i),
    .dest_start_i   (dest_start_i),
    .source_start_i (source_start_i),
    .span_length_i  (span_length_i),
    .seed_key_i     (seed_key_i),
    .cmd_o          (front_cmd)
  );

  crr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (push),
    .wdata_i (front_cmd),
    .full_o  (full),
    .rd_i    (queue_take),
    .valid_o (queue_valid),
    .rdata_o (queue_cmd)
  );

  crr_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (queue_valid),
    .cmd_i           (queue_cmd),
    .cmd_take_o      (queue_take),
    .res_valid_o     (res_valid),
    .res_take_i      (pop),
    .mapped_value_o  (mapped_value_o),
    .lowest_so_far_o (lowest_so_far_o),
    .status_o        (status_o)
  );

  assign empty = !res_valid;

endmodule

// ----- rtl/crr_ram.sv -----
`timescale 1ns / 1ps
module crr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/crr_front.sv -----
`timescale 1ns / 1ps
module crr_front import crr_pkg::*; (
  input  logic [KIND_W-1:0]  kind_i,
  input  logic [STAGE_W-1:0] stage_i,
  input  logic [WORD_W-1:0]  dest_start_i,
  input  logic [WORD_W-1:0]  source_start_i,
  input  logic [WORD_W-1:0]  span_length_i,
  input  logic [WORD_W-1:0]  seed_key_i,
  output cmd_t               cmd_o
);

  logic stage_ok;

  // Flag loads aimed past the last stage.
  assign stage_ok = {{(32-STAGE_W){1'b0}}, stage_i} < 32'(STAGE_COUNT);

  // Classify the item into a back-end operation.
  always_comb begin
    cmd_o.stage = STAGE_IDX_W'(stage_i);
    cmd_o.dst   = dest_start_i;
    cmd_o.src   = source_start_i;
    cmd_o.len   = span_length_i;
    cmd_o.key   = seed_key_i;
    unique case (kind_i)
      KIND_LOAD:  cmd_o.op = stage_ok ? OP_LOAD : OP_DROP;
      KIND_QUERY: cmd_o.op = OP_QUERY;
      KIND_CLEAR: cmd_o.op = OP_CLEAR;
      default:    cmd_o.op = OP_NOP;
    endcase
  end

endmodule

// ----- rtl/crr_queue.sv -----
`timescale 1ns / 1ps
module crr_queue import crr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  cmd_t wdata_i,
  output logic full_o,
  input  logic rd_i,
  output logic valid_o,
  output cmd_t rdata_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o  = cnt_q == CNT_W'(QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign rdata_o = slot_q[rptr_q];
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && valid_o;

  // Advance pointers with wrap.
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    if (do_wr) begin
      wptr_d = (wptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_rd) begin
      rptr_d = (rptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    cnt_d = cnt_q + CNT_W'(do_wr) - CNT_W'(do_rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Store the item.
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slot_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ----- rtl/crr_back.sv -----
`timescale 1ns / 1ps
module crr_back import crr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  cmd_t              cmd_i,
  output logic              cmd_take_o,
  output logic              res_valid_o,
  input  logic              res_take_i,
  output logic [WORD_W-1:0] mapped_value_o,
  output logic [WORD_W-1:0] lowest_so_far_o,
  output logic              status_o
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_READ  = 3'b010,
    S_CHECK = 3'b100
  } state_e;

  state_e                 state_q, state_d;
  logic [WORD_W-1:0]      key_q, key_d;
  logic [SCAN_W-1:0]      scan_q, scan_d;
  logic [FILL_W-1:0]      win_q, win_d;
  logic [FILL_W-1:0]      fill_q [STAGE_COUNT];
  logic [FILL_W-1:0]      fill_d [STAGE_COUNT];
  logic [WORD_W-1:0]      min_q, min_d;
  logic                   res_valid_q, res_valid_d;
  logic [WORD_W-1:0]      res_mapped_q, res_mapped_d;
  logic [WORD_W-1:0]      res_low_q, res_low_d;
  logic                   res_status_q, res_status_d;

  logic [STAGE_IDX_W-1:0] fill_idx;
  logic [FILL_W-1:0]      cur_fill;
  logic                   slot_free;
  logic                   we, re;
  logic [TABLE_AW-1:0]    waddr, raddr;
  logic [ENTRY_W-1:0]     wdata, rdata;
  logic [WORD_W-1:0]      e_dst, e_src, e_len, diff;
  logic                   hit;

  crr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // One fill lookup: load stage while idle, scan stage otherwise.
  assign fill_idx  = (state_q == S_IDLE) ? cmd_i.stage : scan_q[STAGE_IDX_W-1:0];
  assign cur_fill  = fill_q[fill_idx];
  assign slot_free = !res_valid_q || res_take_i;
  assign cmd_take_o = (state_q == S_IDLE) && cmd_valid_i && slot_free;

  assign waddr = TABLE_AW'(cmd_i.stage) * TABLE_AW'(WINDOWS_PER_STAGE)
               + TABLE_AW'(cur_fill[WIN_IDX_W-1:0]);
  assign raddr = TABLE_AW'(scan_q[STAGE_IDX_W-1:0]) * TABLE_AW'(WINDOWS_PER_STAGE)
               + TABLE_AW'(win_q[WIN_IDX_W-1:0]);
  assign wdata = {cmd_i.dst, cmd_i.src, cmd_i.len};
  assign {e_dst, e_src, e_len} = rdata;

  // Window test: key inside [src, src + len) without wrap.
  assign diff = key_q - e_src;
  assign hit  = (key_q >= e_src) && (diff < e_len);

  always_comb begin
    state_d      = state_q;
    key_d        = key_q;
    scan_d       = scan_q;
    win_d        = win_q;
    fill_d       = fill_q;
    min_d        = min_q;
    res_valid_d  = res_valid_q && !res_take_i;
    res_mapped_d = res_mapped_q;
    res_low_d    = res_low_q;
    res_status_d = res_status_q;
    we           = 1'b0;
    re           = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_take_o) begin
          res_mapped_d = '0;
          res_status_d = 1'b0;
          res_low_d    = min_q;
          case (cmd_i.op)
            OP_LOAD: begin
              if (cur_fill < FILL_W'(WINDOWS_PER_STAGE)) begin
                we               = 1'b1;
                fill_d[fill_idx] = cur_fill + 1'b1;
              end else begin
                res_status_d = 1'b1;
              end
              res_valid_d = 1'b1;
            end
            OP_CLEAR: begin
              for (int s = 0; s < STAGE_COUNT; s++) begin
                fill_d[s] = '0;
              end
              min_d       = NO_VALUE;
              res_low_d   = NO_VALUE;
              res_valid_d = 1'b1;
            end
            OP_DROP: begin
              res_status_d = 1'b1;
              res_valid_d  = 1'b1;
            end
            OP_QUERY: begin
              key_d   = cmd_i.key;
              scan_d  = '0;
              win_d   = '0;
              state_d = S_READ;
            end
            default: begin
              res_valid_d = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        if (scan_q == SCAN_W'(STAGE_COUNT)) begin
          // All stages done: post result and fold into the minimum.
          res_mapped_d = key_q;
          res_status_d = 1'b0;
          if (key_q < min_q) begin
            min_d     = key_q;
            res_low_d = key_q;
          end else begin
            res_low_d = min_q;
          end
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else if (win_q >= cur_fill) begin
          scan_d = scan_q + 1'b1;
          win_d  = '0;
        end else begin
          re      = 1'b1;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (hit) begin
          key_d  = e_dst + diff;
          scan_d = scan_q + 1'b1;
          win_d  = '0;
        end else begin
          win_d = win_q + 1'b1;
        end
        state_d = S_READ;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '{default: '0};
      min_q       <= NO_VALUE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      min_q       <= min_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Hold scan and result payload.
  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    scan_q       <= scan_d;
    win_q        <= win_d;
    res_mapped_q <= res_mapped_d;
    res_low_q    <= res_low_d;
    res_status_q <= res_status_d;
  end

  assign res_valid_o     = res_valid_q;
  assign mapped_value_o  = res_mapped_q;
  assign lowest_so_far_o = res_low_q;
  assign status_o        = res_status_q;

endmodule

// ----- rtl/crr_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module crr_checker import crr_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               empty,
  input logic               pop,
  input logic [WORD_W-1:0]  mapped_value_o,
  input logic [WORD_W-1:0]  lowest_so_far_o,
  input logic               status_o
);

  // A waiting result stays put until taken.
  `CRR_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(mapped_value_o), "result changed while stalled")

  // A dropped load reports no mapped value.
  `CRR_ASSERT(a_drop_zero, !empty && status_o |-> mapped_value_o == '0, "dropped load with nonzero value")

  // A query's mapped value never lies below the running minimum.
  `CRR_ASSERT(a_min_bound, !empty && mapped_value_o != '0 |-> lowest_so_far_o <= mapped_value_o, "minimum above mapped value")

endmodule

bind cascaded_range_remap crr_checker u_crr_checker (.*);
